>>> rtl/stx_length_frame_receiver_unit_assert.svh
// Assertion macros used by the checker file of the receiver.
`ifndef STX_LENGTH_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define STX_LENGTH_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("receiver assertion failed");

// Next-cycle implication, checked outside reset.
`define SLFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("receiver assertion failed");

`endif

>>> rtl/slfr_pkg.sv
`timescale 1ns / 1ps

package slfr_pkg;

	localparam logic [7:0]  START_BYTE   = 8'h02;
	localparam logic [7:0]  LEAD_IN_BYTE = 8'h7e;
	localparam logic [7:0]  BCC_POLY     = 8'h85;
	localparam logic [15:0] HEADER_BYTES = 16'd8;
	localparam logic [15:0] CRC_BYTES    = 16'd4;
	localparam logic [15:0] LEN_HI_POS   = 16'd2;
	localparam logic [15:0] LEN_LO_POS   = 16'd3;

	localparam logic [15:0] MAX_PAYLOAD_RESET  = 16'd1024;
	localparam logic [15:0] CHAR_TIMEOUT_RESET = 16'd200;
	localparam logic [15:0] MSG_TIMEOUT_RESET  = 16'd5000;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_ARM  = 2'd2,
		OP_NONE = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		REG_MAX_PAYLOAD  = 2'd0,
		REG_CHAR_TIMEOUT = 2'd1,
		REG_MSG_TIMEOUT  = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_OK_GARBAGE = 3'd1,
		ST_BCC_ERR    = 3'd2,
		ST_LEN_ERR    = 3'd3,
		ST_CHAR_TO    = 3'd4,
		ST_MSG_TO     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HUNT = 2'd1,
		PH_HEAD = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef struct packed {
		logic [15:0] max_payload;
		logic [15:0] char_timeout_ticks;
		logic [15:0] message_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       byte_valid;
		logic       frame_end;
		logic [2:0] status;
	} res_t;

	function automatic logic [7:0] bcc_update(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] v;
		v = acc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ BCC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

>>> rtl/slfr_if.sv
`timescale 1ns / 1ps

interface slfr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] rx_byte;

	modport source (output valid, output opcode, output rx_byte, input ready);
	modport sink (input valid, input opcode, input rx_byte, output ready);
endinterface

interface slfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       byte_valid;
	logic       frame_end;
	logic [2:0] status;

	modport source (output valid, output frame_byte, output byte_valid, output frame_end,
		output status, input ready);
	modport sink (input valid, input frame_byte, input byte_valid, input frame_end,
		input status, output ready);
endinterface

>>> rtl/slfr_cfg_regs.sv
`timescale 1ns / 1ps

module slfr_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output slfr_pkg::cfg_t      cfg
);

	slfr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload           <= slfr_pkg::MAX_PAYLOAD_RESET;
			cfg_q.char_timeout_ticks    <= slfr_pkg::CHAR_TIMEOUT_RESET;
			cfg_q.message_timeout_ticks <= slfr_pkg::MSG_TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (slfr_pkg::reg_index_t'(cfg_index))
				slfr_pkg::REG_MAX_PAYLOAD:  cfg_q.max_payload           <= cfg_data;
				slfr_pkg::REG_CHAR_TIMEOUT: cfg_q.char_timeout_ticks    <= cfg_data;
				slfr_pkg::REG_MSG_TIMEOUT:  cfg_q.message_timeout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/slfr_core.sv
`timescale 1ns / 1ps

module slfr_core (
	input  logic           clk,
	input  logic           arst_n,
	input  slfr_pkg::cfg_t cfg,
	input  logic           accept,
	input  logic [1:0]     opcode,
	input  logic [7:0]     rx_byte,
	output logic           res_push,
	output slfr_pkg::res_t res
);

	slfr_pkg::phase_t phase_q, phase_d;
	logic [15:0] byte_count_q, byte_count_d;
	logic [15:0] payload_length_q, payload_length_d;
	logic [7:0]  bcc_q, bcc_d;
	logic        garbage_q, garbage_d;
	logic [15:0] idle_ticks_q, idle_ticks_d;

	logic [7:0]  bcc_next;
	logic [15:0] ticks_inc;
	logic [15:0] limit;
	logic [15:0] count_inc;
	logic [15:0] len_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= slfr_pkg::PH_IDLE;
			byte_count_q     <= '0;
			payload_length_q <= '0;
			bcc_q            <= '0;
			garbage_q        <= 1'b0;
			idle_ticks_q     <= '0;
		end else begin
			phase_q          <= phase_d;
			byte_count_q     <= byte_count_d;
			payload_length_q <= payload_length_d;
			bcc_q            <= bcc_d;
			garbage_q        <= garbage_d;
			idle_ticks_q     <= idle_ticks_d;
		end
	end

	always_comb begin
		phase_d          = phase_q;
		byte_count_d     = byte_count_q;
		payload_length_d = payload_length_q;
		bcc_d            = bcc_q;
		garbage_d        = garbage_q;
		idle_ticks_d     = idle_ticks_q;
		res_push         = 1'b0;
		res              = '0;

		bcc_next  = slfr_pkg::bcc_update(bcc_q, rx_byte);
		ticks_inc = (idle_ticks_q == 16'hffff) ? idle_ticks_q : idle_ticks_q + 16'd1;
		limit     = (phase_q == slfr_pkg::PH_HUNT) ? cfg.message_timeout_ticks
			: cfg.char_timeout_ticks;
		count_inc = byte_count_q + 16'd1;
		len_new   = payload_length_q;
		if (byte_count_q == slfr_pkg::LEN_HI_POS) begin
			len_new = {rx_byte, payload_length_q[7:0]};
		end else if (byte_count_q == slfr_pkg::LEN_LO_POS) begin
			len_new = {payload_length_q[15:8], rx_byte};
		end

		if (accept) begin
			case (slfr_pkg::opcode_t'(opcode))
				slfr_pkg::OP_ARM: begin
					if (phase_q == slfr_pkg::PH_IDLE) begin
						phase_d          = slfr_pkg::PH_HUNT;
						byte_count_d     = '0;
						payload_length_d = '0;
						bcc_d            = '0;
						garbage_d        = 1'b0;
						idle_ticks_d     = '0;
					end
				end
				slfr_pkg::OP_TICK: begin
					if (phase_q != slfr_pkg::PH_IDLE) begin
						idle_ticks_d = ticks_inc;
						if (ticks_inc >= limit) begin
							res_push       = 1'b1;
							res.frame_end  = 1'b1;
							res.status     = (phase_q == slfr_pkg::PH_HUNT) ? slfr_pkg::ST_MSG_TO
								: slfr_pkg::ST_CHAR_TO;
							phase_d        = slfr_pkg::PH_IDLE;
						end
					end
				end
				slfr_pkg::OP_BYTE: begin
					if (phase_q != slfr_pkg::PH_IDLE) begin
						idle_ticks_d   = '0;
						res.frame_byte = rx_byte;
						res.byte_valid = 1'b1;
					end
					case (phase_q)
						slfr_pkg::PH_HUNT: begin
							if (rx_byte == slfr_pkg::START_BYTE) begin
								bcc_d        = slfr_pkg::bcc_update(8'h00, rx_byte);
								byte_count_d = 16'd1;
								phase_d      = slfr_pkg::PH_HEAD;
								res_push     = 1'b1;
							end else if (rx_byte != slfr_pkg::LEAD_IN_BYTE) begin
								garbage_d = 1'b1;
							end
						end
						slfr_pkg::PH_HEAD: begin
							bcc_d            = bcc_next;
							payload_length_d = len_new;
							byte_count_d     = count_inc;
							res_push         = 1'b1;
							if (count_inc >= slfr_pkg::HEADER_BYTES) begin
								if (len_new > cfg.max_payload) begin
									res.frame_end = 1'b1;
									res.status    = slfr_pkg::ST_LEN_ERR;
									phase_d       = slfr_pkg::PH_IDLE;
								end else begin
									byte_count_d     = len_new;
									payload_length_d = '0;
									phase_d          = slfr_pkg::PH_BODY;
								end
							end
						end
						slfr_pkg::PH_BODY: begin
							res_push = 1'b1;
							if (byte_count_q != '0) begin
								byte_count_d = byte_count_q - 16'd1;
								bcc_d        = bcc_next;
							end else if (payload_length_q < slfr_pkg::CRC_BYTES) begin
								payload_length_d = payload_length_q + 16'd1;
								bcc_d            = bcc_next;
							end else begin
								res.frame_end = 1'b1;
								phase_d       = slfr_pkg::PH_IDLE;
								if (rx_byte != bcc_q) begin
									res.status = slfr_pkg::ST_BCC_ERR;
								end else if (garbage_q) begin
									res.status = slfr_pkg::ST_OK_GARBAGE;
								end else begin
									res.status = slfr_pkg::ST_OK;
								end
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/slfr_out_buf.sv
`timescale 1ns / 1ps

module slfr_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  slfr_pkg::res_t push_data,
	output logic           space,
	output logic           pop_valid,
	input  logic           pop_ready,
	output slfr_pkg::res_t pop_data
);

	slfr_pkg::res_t buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign space     = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/stx_length_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Fields
// items     sink       opcode[1:0], rx_byte[7:0]
// results   source     frame_byte[7:0], byte_valid, frame_end, status[2:0]
// config    write      cfg_we, cfg_index[1:0], cfg_data[15:0]
//
// A new request is taken every cycle while the two-entry result buffer has room,
// and any result that it yields is registered in that buffer.
// The frame state updates in one pass through the BCC (polynomial 0x85) and counter logic.
// Reset returns the receiver to idle and the registers to their defaults.
// A stalled result side holds items back only once both buffer entries fill.

module stx_length_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	slfr_in_if.sink     items,
	slfr_out_if.source  results,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	slfr_pkg::cfg_t cfg;
	slfr_pkg::res_t core_res;
	slfr_pkg::res_t out_res;
	logic           core_push;
	logic           space;
	logic           accept;

	assign items.ready = space;
	assign accept      = items.valid && space;

	slfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slfr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.opcode   (items.opcode),
		.rx_byte  (items.rx_byte),
		.res_push (core_push),
		.res      (core_res)
	);

	slfr_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (core_push),
		.push_data (core_res),
		.space     (space),
		.pop_valid (results.valid),
		.pop_ready (results.ready),
		.pop_data  (out_res)
	);

	assign results.frame_byte = out_res.frame_byte;
	assign results.byte_valid = out_res.byte_valid;
	assign results.frame_end  = out_res.frame_end;
	assign results.status     = out_res.status;

endmodule

>>> rtl/slfr_checker.sv
`timescale 1ns / 1ps
`include "stx_length_frame_receiver_unit_assert.svh"

module slfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] frame_byte,
	input logic       byte_valid,
	input logic       frame_end,
	input logic [2:0] status
);

	logic any_to;

	assign any_to = (status == slfr_pkg::ST_CHAR_TO) || (status == slfr_pkg::ST_MSG_TO);

	`SLFR_ASSERT_SAME(a_status_only_at_end, clk, arst_n, res_valid && !frame_end, status == slfr_pkg::ST_OK)
	`SLFR_ASSERT_SAME(a_no_byte_is_timeout, clk, arst_n, res_valid && !byte_valid, frame_end && any_to && frame_byte == 8'h00)
	`SLFR_ASSERT_SAME(a_timeout_has_no_byte, clk, arst_n, res_valid && frame_end && any_to, !byte_valid)
	`SLFR_ASSERT_NEXT(a_stall_holds, clk, arst_n, res_valid && !res_ready, res_valid && $stable(frame_byte) && $stable(status) && $stable(frame_end))

endmodule

bind stx_length_frame_receiver_unit slfr_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.frame_byte (results.frame_byte),
	.byte_valid (results.byte_valid),
	.frame_end  (results.frame_end),
	.status     (results.status)
);
